### hdl/beq_pkg.sv
// bounded event queue: shared types and constants
// entry layout, op and status codes, register map and reset values
// no dependencies
package beq_pkg;

   localparam int unsigned CAPACITY_DEFAULT = 64;

   // one queued event
   typedef struct packed {
      logic        is_resize;
      logic [15:0] window;
      logic [31:0] payload;
      logic [31:0] sequence_no;
   } entry_type;

   // op codes
   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_FRONT = 2'd1;
   localparam logic [1:0] OP_POP   = 2'd2;

   // status codes
   localparam logic [2:0] ST_ENQUEUED      = 3'd0;
   localparam logic [2:0] ST_ENQ_EVICTED   = 3'd1;
   localparam logic [2:0] ST_COALESCED     = 3'd2;
   localparam logic [2:0] ST_REFUSED       = 3'd3;
   localparam logic [2:0] ST_REFUSED_EVICT = 3'd4;
   localparam logic [2:0] ST_POPPED        = 3'd5;
   localparam logic [2:0] ST_POP_EMPTY     = 3'd6;
   localparam logic [2:0] ST_UNKNOWN_OP    = 3'd7;

   // register map (word index)
   localparam int unsigned ADDR_W = 4;
   localparam logic [1:0] REG_DEPTH_LIMIT = 2'd0;
   localparam logic [1:0] REG_POLICY      = 2'd1;
   localparam logic [1:0] REG_COALESCE    = 2'd2;

   localparam logic [6:0] DEPTH_LIMIT_RESET = 7'd64;

endpackage

### hdl/bounded_event_queue.sv
// bounded event queue: ring of events with merge and drop policies
// depends on beq_pkg (entry type, codes, register map)
//
//   channel  direction  beat
//   req      in         op, is_resize, window, payload, sequence_in
//   rsp      out        status, popped event, level and running totals
//   csr      in/out     apb-style access to depth limit, overflow policy, merge enable
//
// one item per cycle sustained while rsp is ready; an accepted beat is held in the input
// register and its result is registered when it moves on. head and tail entries are read
// from the ring memory into registers, addressed from the next-state head and level, with
// a bypass when the same edge writes that slot. synchronous active-high reset empties
// the queue; the ring itself is not cleared. rsp stalls back up through the input
// register to req_ready.
module bounded_event_queue #(
   parameter int unsigned CAPACITY = beq_pkg::CAPACITY_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   // input beats
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic                        req_is_resize,
   input  logic [15:0]                 req_window,
   input  logic [31:0]                 req_payload,
   input  logic [31:0]                 req_sequence_in,
   // result beats
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [2:0]                  rsp_status,
   output logic                        rsp_out_valid,
   output logic                        rsp_out_is_resize,
   output logic [15:0]                 rsp_out_window,
   output logic [31:0]                 rsp_out_payload,
   output logic [31:0]                 rsp_out_sequence,
   output logic [6:0]                  rsp_level,
   output logic [31:0]                 rsp_dropped_total,
   output logic [31:0]                 rsp_coalesce_total,
   output logic [31:0]                 rsp_last_sequence,
   // configuration
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [beq_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int unsigned IW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned MW = (CW > 7) ? CW : 7;
   localparam int unsigned SW = CW + 1;
   localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
   localparam logic [IW-1:0] LAST_C = IW'(CAPACITY - 1);

   // configuration registers
   logic [6:0] depth_cfg_ff;
   logic       policy_ff;
   logic       coalesce_ff;

   // queue state
   logic [IW-1:0] head_ff,  head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [31:0]   nseq_ff,  nseq_in;
   logic [31:0]   last_ff,  last_in;
   logic [31:0]   drop_ff,  drop_in;
   logic [31:0]   merge_ff, merge_in;

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  op_ff;
   logic        rs_ff;
   logic [15:0] win_ff;
   logic [31:0] pl_ff;
   logic [31:0] sqin_ff;

   // ring memory and its registered reads
   beq_pkg::entry_type ring [CAPACITY];
   beq_pkg::entry_type hrd_ff, trd_ff, wbyp_ff;
   logic               hit_h_ff, hit_t_ff;
   beq_pkg::entry_type head_ent, tail_ent;
   logic [IW-1:0]      raddr_h, raddr_t;

   // write port
   logic               we;
   logic [IW-1:0]      waddr;
   beq_pkg::entry_type wdata;

   // result register
   logic        rsp_valid_ff;
   logic [2:0]  status_ff,  status_in;
   logic        ovalid_ff,  ovalid_in;
   beq_pkg::entry_type oent_ff, oent_in;
   logic [6:0]  level_ff;

   logic       x_fire;
   logic       csr_wr;
   logic [CW-1:0] depth;
   logic [MW-1:0] md_ext;

   function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] h, input logic [CW-1:0] n);
      logic [SW-1:0] s;
      s = SW'(h) + SW'(n);
      if (s >= SW'(CAPACITY)) begin
         s = s - SW'(CAPACITY);
      end
      return s[IW-1:0];
   endfunction

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [CW-1:0] n);
      logic [32:0] s;
      s = {1'b0, a} + 33'(n);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   // ---------------------------------------------------------------- configuration
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_cfg_ff <= beq_pkg::DEPTH_LIMIT_RESET;
         policy_ff    <= 1'b0;
         coalesce_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            beq_pkg::REG_DEPTH_LIMIT: depth_cfg_ff <= csr_pwdata[6:0];
            beq_pkg::REG_POLICY:      policy_ff    <= csr_pwdata[0];
            beq_pkg::REG_COALESCE:    coalesce_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         beq_pkg::REG_DEPTH_LIMIT: csr_prdata = {25'd0, depth_cfg_ff};
         beq_pkg::REG_POLICY:      csr_prdata = {31'd0, policy_ff};
         beq_pkg::REG_COALESCE:    csr_prdata = {31'd0, coalesce_ff};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   // zero or oversize depth means full capacity
   assign md_ext = MW'(depth_cfg_ff);
   assign depth  = (depth_cfg_ff == 7'd0 || md_ext > MW'(CAPACITY)) ? CAP_C : CW'(md_ext);

   // ---------------------------------------------------------------- handshakes
   assign x_fire      = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready   = ~in_valid_ff | x_fire;
   assign in_valid_in = (req_valid & req_ready) | (in_valid_ff & ~x_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         op_ff   <= req_op;
         rs_ff   <= req_is_resize;
         win_ff  <= req_window;
         pl_ff   <= req_payload;
         sqin_ff <= req_sequence_in;
      end
   end

   // ---------------------------------------------------------------- ring memory
   assign head_ent = hit_h_ff ? wbyp_ff : hrd_ff;
   assign tail_ent = hit_t_ff ? wbyp_ff : trd_ff;

   // reads for the next beat follow the next-state head and level
   assign raddr_h = head_in;
   assign raddr_t = (count_in == '0) ? head_in : wrap_add(head_in, count_in - CW'(1));

   always_ff @(posedge clock) begin
      if (we) begin
         ring[waddr] <= wdata;
      end
      hrd_ff  <= ring[raddr_h];
      trd_ff  <= ring[raddr_t];
      wbyp_ff <= wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_h_ff <= 1'b0;
         hit_t_ff <= 1'b0;
      end else begin
         hit_h_ff <= we & (waddr == raddr_h);
         hit_t_ff <= we & (waddr == raddr_t);
      end
   end

   // ---------------------------------------------------------------- update
   always_comb begin
      logic          merge;
      logic          full;
      logic          evicted;
      logic          ok;
      logic [CW-1:0] cnt1;
      logic [31:0]   seq;

      head_in   = head_ff;
      count_in  = count_ff;
      nseq_in   = nseq_ff;
      last_in   = last_ff;
      drop_in   = drop_ff;
      merge_in  = merge_ff;
      status_in = beq_pkg::ST_UNKNOWN_OP;
      ovalid_in = 1'b0;
      oent_in   = '0;
      we        = 1'b0;
      waddr     = wrap_add(head_ff, count_ff);
      wdata     = '{is_resize: rs_ff, window: win_ff, payload: pl_ff, sequence_no: nseq_ff + 32'd1};
      merge     = 1'b0;
      full      = (count_ff != '0) && (count_ff >= depth);
      evicted   = 1'b0;
      ok        = 1'b1;
      cnt1      = count_ff;
      seq       = nseq_ff + 32'd1;

      if (x_fire) begin
         case (op_ff)
            beq_pkg::OP_PUSH: begin
               merge = coalesce_ff && (count_ff != '0) && rs_ff
                       && tail_ent.is_resize && (tail_ent.window == win_ff);
               if (merge) begin
                  we        = 1'b1;
                  waddr     = (count_ff == '0) ? head_ff : wrap_add(head_ff, count_ff - CW'(1));
                  wdata     = tail_ent;
                  wdata.payload = pl_ff;
                  merge_in  = sat_add(merge_ff, CW'(1));
                  status_in = beq_pkg::ST_COALESCED;
               end else begin
                  if (full && !policy_ff) begin
                     head_in = (head_ff == LAST_C) ? '0 : head_ff + IW'(1);
                     cnt1    = count_ff - CW'(1);
                     drop_in = sat_add(drop_ff, CW'(1));
                     evicted = 1'b1;
                     ok      = cnt1 < depth;
                  end else if (full) begin
                     drop_in = sat_add(drop_ff, CW'(1));
                     ok      = 1'b0;
                  end
                  if (ok) begin
                     // evicting the head keeps the tail slot where it was
                     we        = 1'b1;
                     nseq_in   = seq;
                     last_in   = seq;
                     count_in  = cnt1 + CW'(1);
                     status_in = evicted ? beq_pkg::ST_ENQ_EVICTED : beq_pkg::ST_ENQUEUED;
                  end else begin
                     count_in  = cnt1;
                     status_in = evicted ? beq_pkg::ST_REFUSED_EVICT : beq_pkg::ST_REFUSED;
                  end
               end
            end
            beq_pkg::OP_FRONT: begin
               // drop from the tail until one slot is free under the limit
               if (full) begin
                  cnt1    = depth - CW'(1);
                  drop_in = sat_add(drop_ff, count_ff - depth + CW'(1));
                  evicted = 1'b1;
               end
               if (sqin_ff == 32'd0) begin
                  nseq_in = seq;
               end else begin
                  seq = sqin_ff;
               end
               last_in   = seq;
               head_in   = (head_ff == '0) ? LAST_C : head_ff - IW'(1);
               we        = 1'b1;
               waddr     = head_in;
               wdata.sequence_no = seq;
               count_in  = cnt1 + CW'(1);
               status_in = evicted ? beq_pkg::ST_ENQ_EVICTED : beq_pkg::ST_ENQUEUED;
            end
            beq_pkg::OP_POP: begin
               if (count_ff == '0) begin
                  status_in = beq_pkg::ST_POP_EMPTY;
               end else begin
                  ovalid_in = 1'b1;
                  oent_in   = head_ent;
                  head_in   = (head_ff == LAST_C) ? '0 : head_ff + IW'(1);
                  count_in  = count_ff - CW'(1);
                  status_in = beq_pkg::ST_POPPED;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         nseq_ff  <= '0;
         last_ff  <= '0;
         drop_ff  <= '0;
         merge_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         nseq_ff  <= nseq_in;
         last_ff  <= last_in;
         drop_ff  <= drop_in;
         merge_ff <= merge_in;
      end
   end

   // ---------------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (x_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (x_fire) begin
         status_ff <= status_in;
         ovalid_ff <= ovalid_in;
         oent_ff   <= oent_in;
         level_ff  <= 7'(count_in);
      end
   end

   // totals are sampled with the beat they belong to
   logic [31:0] drop_out_ff, merge_out_ff, last_out_ff;

   always_ff @(posedge clock) begin
      if (x_fire) begin
         drop_out_ff  <= drop_in;
         merge_out_ff <= merge_in;
         last_out_ff  <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_out_valid      = ovalid_ff;
   assign rsp_out_is_resize  = oent_ff.is_resize;
   assign rsp_out_window     = oent_ff.window;
   assign rsp_out_payload    = oent_ff.payload;
   assign rsp_out_sequence   = oent_ff.sequence_no;
   assign rsp_level          = level_ff;
   assign rsp_dropped_total  = drop_out_ff;
   assign rsp_coalesce_total = merge_out_ff;
   assign rsp_last_sequence  = last_out_ff;

endmodule

### sim/bounded_event_queue_checker.sv
`timescale 1ns / 1ps
// bounded event queue checker: watches req, rsp and csr, keeps its own copy of the ring
// and registers, predicts every result beat and compares it field by field
// depends on beq_pkg
module bounded_event_queue_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_ready,
   input  logic [1:0]                  req_op,
   input  logic                        req_is_resize,
   input  logic [15:0]                 req_window,
   input  logic [31:0]                 req_payload,
   input  logic [31:0]                 req_sequence_in,
   input  logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  logic [2:0]                  rsp_status,
   input  logic                        rsp_out_valid,
   input  logic                        rsp_out_is_resize,
   input  logic [15:0]                 rsp_out_window,
   input  logic [31:0]                 rsp_out_payload,
   input  logic [31:0]                 rsp_out_sequence,
   input  logic [6:0]                  rsp_level,
   input  logic [31:0]                 rsp_dropped_total,
   input  logic [31:0]                 rsp_coalesce_total,
   input  logic [31:0]                 rsp_last_sequence,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [beq_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   input  logic                        csr_pready,
   output int                          failures,
   output int                          outstanding,
   output int                          results_checked,
   output logic [7:0]                  statuses_seen
);

   localparam int RING = beq_pkg::CAPACITY_DEFAULT;
   localparam int PEND_DEPTH = 16;
   typedef logic [$clog2(RING)-1:0] slot_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        out_valid;
      logic        out_is_resize;
      logic [15:0] out_window;
      logic [31:0] out_payload;
      logic [31:0] out_sequence;
      logic [6:0]  level;
      logic [31:0] dropped_total;
      logic [31:0] coalesce_total;
      logic [31:0] last_sequence;
   } outcome_type;

   beq_pkg::entry_type ring [RING];
   slot_type           head;
   logic [6:0]         level;
   logic [31:0]        seq_counter;
   logic [31:0]        last_enqueued;
   logic [31:0]        drops;
   logic [31:0]        merges;
   logic [6:0]         depth_cfg;
   logic               policy_cfg;
   logic               coalesce_cfg;

   // predicted result beats waiting for the block, oldest at pend_rd
   outcome_type        pending [PEND_DEPTH];
   int                 pend_rd;
   int                 pend_wr;
   int                 pend_count;

   function automatic logic [31:0] saturating_bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // applies one request beat to the shadow queue and returns the result it should give
   function automatic outcome_type advance_event_queue(input logic [1:0] op,
      input logic rs, input logic [15:0] win, input logic [31:0] pl, input logic [31:0] sq_in);
      outcome_type    o;
      logic [6:0]     limit;
      logic           merged;
      logic           evicted;
      logic           room;
      slot_type       slot;
      logic [31:0]    sq;
      o = '0;
      merged = 1'b0;
      evicted = 1'b0;
      room = 1'b1;
      limit = (depth_cfg == 7'd0 || depth_cfg > 7'(RING)) ? 7'(RING) : depth_cfg;
      case (op)
         beq_pkg::OP_PUSH: begin
            if (coalesce_cfg && level > 7'd0 && rs) begin
               slot = slot_type'(head + level - 7'd1);
               if (ring[slot].is_resize && ring[slot].window == win) begin
                  ring[slot].payload = pl;
                  merges = saturating_bump(merges);
                  merged = 1'b1;
                  o.status = beq_pkg::ST_COALESCED;
               end
            end
            if (!merged) begin
               if (level > 7'd0 && level >= limit) begin
                  drops = saturating_bump(drops);
                  if (!policy_cfg) begin
                     // drop oldest: one eviction only, may still leave no room
                     head = head + 1'b1;
                     level = level - 7'd1;
                     evicted = 1'b1;
                     room = level < limit;
                     if (!room)
                        o.status = beq_pkg::ST_REFUSED_EVICT;
                  end else begin
                     room = 1'b0;
                     o.status = beq_pkg::ST_REFUSED;
                  end
               end
               if (room) begin
                  seq_counter = seq_counter + 32'd1;
                  last_enqueued = seq_counter;
                  slot = slot_type'(head + level);
                  ring[slot] = '{is_resize: rs, window: win, payload: pl,
                                 sequence_no: seq_counter};
                  level = level + 7'd1;
                  o.status = evicted ? beq_pkg::ST_ENQ_EVICTED : beq_pkg::ST_ENQUEUED;
               end
            end
         end
         beq_pkg::OP_FRONT: begin
            // front push trims from the tail until one slot is free
            while (level > 7'd0 && level >= limit) begin
               level = level - 7'd1;
               drops = saturating_bump(drops);
               evicted = 1'b1;
            end
            if (sq_in == 32'd0) begin
               seq_counter = seq_counter + 32'd1;
               sq = seq_counter;
            end else begin
               sq = sq_in;
            end
            last_enqueued = sq;
            head = head - 1'b1;
            ring[head] = '{is_resize: rs, window: win, payload: pl, sequence_no: sq};
            level = level + 7'd1;
            o.status = evicted ? beq_pkg::ST_ENQ_EVICTED : beq_pkg::ST_ENQUEUED;
         end
         beq_pkg::OP_POP: begin
            if (level == 7'd0) begin
               o.status = beq_pkg::ST_POP_EMPTY;
            end else begin
               o.out_valid = 1'b1;
               o.out_is_resize = ring[head].is_resize;
               o.out_window = ring[head].window;
               o.out_payload = ring[head].payload;
               o.out_sequence = ring[head].sequence_no;
               head = head + 1'b1;
               level = level - 7'd1;
               o.status = beq_pkg::ST_POPPED;
            end
         end
         default: begin
            o.status = beq_pkg::ST_UNKNOWN_OP;
         end
      endcase
      o.level = level;
      o.dropped_total = drops;
      o.coalesce_total = merges;
      o.last_sequence = last_enqueued;
      return o;
   endfunction

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         if (failures < 10)
            $display("mismatch on result beat %0d: %s expected %h got %h",
                     results_checked, field, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         head = '0;
         level = '0;
         seq_counter = '0;
         last_enqueued = '0;
         drops = '0;
         merges = '0;
         depth_cfg = beq_pkg::DEPTH_LIMIT_RESET;
         policy_cfg = 1'b0;
         coalesce_cfg = 1'b0;
         failures = 0;
         results_checked = 0;
         statuses_seen = '0;
         pend_rd = 0;
         pend_wr = 0;
         pend_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[beq_pkg::ADDR_W-1:2])
               beq_pkg::REG_DEPTH_LIMIT: depth_cfg = csr_pwdata[6:0];
               beq_pkg::REG_POLICY:      policy_cfg = csr_pwdata[0];
               beq_pkg::REG_COALESCE:    coalesce_cfg = csr_pwdata[0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pend_count == 0) begin
               if (failures < 10)
                  $display("result beat with status %0d arrived with nothing pending",
                           rsp_status);
               failures++;
            end else begin
               want = pending[pend_rd];
               pend_rd = (pend_rd + 1) % PEND_DEPTH;
               pend_count--;
               check_field("status", 32'(rsp_status), 32'(want.status));
               check_field("out_valid", 32'(rsp_out_valid), 32'(want.out_valid));
               check_field("out_is_resize", 32'(rsp_out_is_resize), 32'(want.out_is_resize));
               check_field("out_window", 32'(rsp_out_window), 32'(want.out_window));
               check_field("out_payload", rsp_out_payload, want.out_payload);
               check_field("out_sequence", rsp_out_sequence, want.out_sequence);
               check_field("level", 32'(rsp_level), 32'(want.level));
               check_field("dropped_total", rsp_dropped_total, want.dropped_total);
               check_field("coalesce_total", rsp_coalesce_total, want.coalesce_total);
               check_field("last_sequence", rsp_last_sequence, want.last_sequence);
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            want = advance_event_queue(req_op, req_is_resize, req_window, req_payload,
                                       req_sequence_in);
            statuses_seen[want.status] = 1'b1;
            if (pend_count == PEND_DEPTH) begin
               if (failures < 10)
                  $display("more than %0d request beats in flight", PEND_DEPTH);
               failures++;
            end else begin
               pending[pend_wr] = want;
               pend_wr = (pend_wr + 1) % PEND_DEPTH;
               pend_count++;
            end
         end
      end
      outstanding <= pend_count;
   end

endmodule

### sim/bounded_event_queue_test.sv
`timescale 1ns / 1ps
// bounded event queue testbench top: clock, reset, request and register stimulus, verdict
// depends on beq_pkg, bounded_event_queue and bounded_event_queue_checker
module bounded_event_queue_test;

   localparam logic [1:0] OP_UNDEFINED = 2'd3;
   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_CYCLES = 60;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic [1:0]                  req_op = beq_pkg::OP_PUSH;
   logic                        req_is_resize = 1'b0;
   logic [15:0]                 req_window = '0;
   logic [31:0]                 req_payload = '0;
   logic [31:0]                 req_sequence_in = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic [2:0]                  rsp_status;
   logic                        rsp_out_valid;
   logic                        rsp_out_is_resize;
   logic [15:0]                 rsp_out_window;
   logic [31:0]                 rsp_out_payload;
   logic [31:0]                 rsp_out_sequence;
   logic [6:0]                  rsp_level;
   logic [31:0]                 rsp_dropped_total;
   logic [31:0]                 rsp_coalesce_total;
   logic [31:0]                 rsp_last_sequence;
   logic                        csr_psel = 1'b0;
   logic                        csr_penable = 1'b0;
   logic                        csr_pwrite = 1'b0;
   logic [beq_pkg::ADDR_W-1:0]  csr_paddr = '0;
   logic [31:0]                 csr_pwdata = '0;
   logic [31:0]                 csr_prdata;
   logic                        csr_pready;

   int                  failures;
   int                  outstanding;
   int                  results_checked;
   logic [7:0]          statuses_seen;

   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  hold_requests = 0;
   int                  holds_done = 0;
   int                  beats_sent = 0;
   int                  config_writes = 0;
   int                  quiet_cycles = 0;
   logic [6:0]          depth_plan [0:7] = '{7'd3, 7'd64, 7'd1, 7'd0, 7'd127, 7'd2,
                                             7'd8, 7'd64};

   bounded_event_queue dut (.*);
   bounded_event_queue_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("bounded_event_queue_test NOT OK");
            $finish;
         end
      end
   end

   // valid stays high after the beat is taken; the next call lowers it only for a gap
   task automatic send_beat(input logic [1:0] op, input logic rs, input logic [15:0] win,
                            input logic [31:0] pl, input logic [31:0] sq);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_is_resize <= rs;
      req_window <= win;
      req_payload <= pl;
      req_sequence_in <= sq;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_random(input int pop_pct);
      int          roll;
      logic [1:0]  op;
      logic [15:0] win;
      logic [31:0] sq;
      roll = $urandom_range(99);
      if (roll < 3)
         op = OP_UNDEFINED;
      else if (roll < 3 + pop_pct)
         op = beq_pkg::OP_POP;
      else if (roll < 23 + pop_pct)
         op = beq_pkg::OP_FRONT;
      else
         op = beq_pkg::OP_PUSH;
      // mostly a handful of windows so that merges actually hit
      win = ($urandom_range(3) != 0) ? 16'($urandom_range(3)) : 16'($urandom_range(16'hFFFF));
      sq = ($urandom_range(1) != 0) ? 32'd0 : $urandom;
      send_beat(op, ($urandom_range(99) < 70), win, $urandom, sq);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      config_writes++;
      @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] depth, input logic policy, input logic merge);
      drain();
      write_reg(beq_pkg::REG_DEPTH_LIMIT, 32'(depth));
      write_reg(beq_pkg::REG_POLICY, 32'(policy));
      write_reg(beq_pkg::REG_COALESCE, 32'(merge));
   endtask

   initial begin
      int         seg;
      int         n;
      int         pop_pct;
      logic [6:0] depth;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty pop, undefined op, field extremes, fresh and given front sequences
      send_beat(beq_pkg::OP_POP, 1'b0, 16'h0000, 32'h0, 32'h0);
      send_beat(OP_UNDEFINED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
      send_beat(beq_pkg::OP_FRONT, 1'b0, 16'h0000, 32'h0, 32'h0);
      send_beat(beq_pkg::OP_FRONT, 1'b1, 16'h1234, 32'hA5A5_A5A5, 32'hFFFF_FFFF);
      repeat (4) send_beat(beq_pkg::OP_POP, 1'b0, 16'h0000, 32'h0, 32'h0);

      // merge on empty, merge hit, drop oldest, front push trimming the tail, refused push
      configure(7'd2, 1'b0, 1'b1);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'd7, 32'd1, 32'd0);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'd7, 32'd2, 32'd0);
      send_beat(beq_pkg::OP_PUSH, 1'b0, 16'd7, 32'd3, 32'd0);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'd8, 32'd4, 32'd0);
      send_beat(beq_pkg::OP_FRONT, 1'b0, 16'd9, 32'd5, 32'd5);
      configure(7'd2, 1'b1, 1'b1);
      send_beat(beq_pkg::OP_PUSH, 1'b0, 16'd10, 32'd6, 32'd0);

      // limit dropped under the level: refused after evicting, then a deep front trim
      configure(7'd64, 1'b0, 1'b0);
      repeat (3) send_beat(beq_pkg::OP_PUSH, 1'b0, 16'd11, $urandom, 32'd0);
      configure(7'd1, 1'b0, 1'b0);
      send_beat(beq_pkg::OP_PUSH, 1'b0, 16'd12, 32'd7, 32'd0);
      send_beat(beq_pkg::OP_FRONT, 1'b1, 16'd13, 32'd8, 32'd0);
      configure(7'd0, 1'b0, 1'b1);
      send_beat(beq_pkg::OP_PUSH, 1'b1, 16'd13, 32'd9, 32'd0);
      repeat (2) send_beat(beq_pkg::OP_POP, 1'b0, 16'h0000, 32'h0, 32'h0);

      for (seg = 0; seg < 8; seg++) begin
         case (seg % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 53; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 53; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         depth = (seg == 6) ? 7'($urandom_range(4, 16)) : depth_plan[seg];
         // fewer pops where the limit is large so the ring still fills
         pop_pct = (depth == 7'd0 || depth >= 7'd64) ? 20 : 35;
         configure(depth, seg[0], seg[1]);
         for (n = 0; n < 55; n++) begin
            if (n == 25 && (seg == 0 || seg == 4))
               hold_requests <= hold_requests + 1;
            if (n == 25 && seg == 5)
               drain();
            send_random(pop_pct);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("sent %0d request beats, checked %0d result beats, %0d register writes",
               beats_sent, results_checked, config_writes);
      $display("status codes seen (bit per code): %b, with hold-off and drain phases",
               statuses_seen);
      if (failures == 0 && outstanding == 0)
         $display("bounded_event_queue_test OK");
      else
         $display("bounded_event_queue_test NOT OK");
      $finish;
   end

endmodule
